// ===== rtl/necir_pkg.sv =====
// Package for the NEC infrared frame decoder.
// Holds the configuration register indexes, their reset values and shared types.
// It has no dependencies.
`default_nettype none

package necir_pkg;

  localparam int unsigned ElapsedInWidth      = 24;
  localparam int unsigned ElapsedWidthDefault = 24;
  localparam int unsigned CfgDataWidth        = 16;
  localparam int unsigned CfgIndexWidth       = 3;
  localparam int unsigned PosWidth            = 7;

  localparam logic [PosWidth-1:0] LastDataPos = 7'd66;
  localparam logic [31:0]         FrameAllOnes = 32'hFFFF_FFFF;

  localparam logic [CfgDataWidth-1:0] LeaderMaxReset = 16'd13750;
  localparam logic [CfgDataWidth-1:0] LeaderMinReset = 16'd10000;
  localparam logic [CfgDataWidth-1:0] SpaceMaxReset  = 16'd6875;
  localparam logic [CfgDataWidth-1:0] SpaceMinReset  = 16'd3750;
  localparam logic [CfgDataWidth-1:0] BitMaxReset    = 16'd2875;
  localparam logic [CfgDataWidth-1:0] BitMinReset    = 16'd250;
  localparam logic [CfgDataWidth-1:0] OneThreshReset = 16'd1250;

  typedef enum logic [CfgIndexWidth-1:0] {
    CfgLeaderMax = 3'd0,
    CfgLeaderMin = 3'd1,
    CfgSpaceMax  = 3'd2,
    CfgSpaceMin  = 3'd3,
    CfgBitMax    = 3'd4,
    CfgBitMin    = 3'd5,
    CfgOneThresh = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgDataWidth-1:0] leader_max;
    logic [CfgDataWidth-1:0] leader_min;
    logic [CfgDataWidth-1:0] space_max;
    logic [CfgDataWidth-1:0] space_min;
    logic [CfgDataWidth-1:0] bit_max;
    logic [CfgDataWidth-1:0] bit_min;
    logic [CfgDataWidth-1:0] one_thresh;
  } timing_cfg_t;

  typedef struct packed {
    logic        done;
    logic        valid;
    logic [31:0] frame;
  } step_res_t;

endpackage

`default_nettype wire

// ===== rtl/necir_step.sv =====
// Next-state logic for one sensor edge of the NEC infrared frame decoder.
// Window check, bit shifting and frame latching; purely combinational.
// Depends on necir_pkg.
`default_nettype none

module necir_step #(
  parameter int unsigned ElapsedWidth = necir_pkg::ElapsedWidthDefault
) (
  input  wire necir_pkg::timing_cfg_t                   cfg_i,
  input  wire logic [necir_pkg::ElapsedInWidth-1:0]     elapsed_ticks_i,
  input  wire logic                                     pin_level_i,
  input  wire logic [necir_pkg::PosWidth-1:0]           pos_i,
  input  wire logic [31:0]                              shifter_i,
  input  wire logic [31:0]                              held_i,
  output logic [necir_pkg::PosWidth-1:0]                pos_o,
  output logic [31:0]                                   shifter_o,
  output necir_pkg::step_res_t                          res_o
);
  import necir_pkg::*;

  localparam int unsigned EffWidth =
    (ElapsedWidth < ElapsedInWidth) ? ElapsedWidth : ElapsedInWidth;

  logic [EffWidth-1:0] elapsed;
  logic [EffWidth-1:0] lo;
  logic [EffWidth-1:0] hi;
  logic                in_window;
  logic                bit_val;
  logic [PosWidth-1:0] pos_inc;
  logic [31:0]         shifted;

  assign elapsed = elapsed_ticks_i[EffWidth-1:0];
  assign bit_val = (elapsed > EffWidth'(cfg_i.one_thresh));
  assign pos_inc = pos_i + PosWidth'(1);
  assign shifted = {shifter_i[30:0], bit_val};

  always_comb begin
    if (pos_i <= PosWidth'(1)) begin
      lo = EffWidth'(cfg_i.leader_min);
      hi = EffWidth'(cfg_i.leader_max);
    end else if (pos_i == PosWidth'(2)) begin
      lo = EffWidth'(cfg_i.space_min);
      hi = EffWidth'(cfg_i.space_max);
    end else begin
      lo = EffWidth'(cfg_i.bit_min);
      hi = EffWidth'(cfg_i.bit_max);
    end
  end

  assign in_window = (elapsed > lo) && (elapsed < hi);

  always_comb begin
    pos_o         = pos_i;
    shifter_o     = shifter_i;
    res_o.done    = 1'b0;
    res_o.valid   = 1'b0;
    res_o.frame   = held_i;
    if (!in_window) begin
      pos_o       = pin_level_i ? PosWidth'(0) : PosWidth'(1);
      res_o.frame = FrameAllOnes;
    end else if (pos_i == PosWidth'(1)) begin
      pos_o = pin_level_i ? PosWidth'(2) : PosWidth'(0);
    end else if (pos_i == PosWidth'(2)) begin
      pos_o = pin_level_i ? PosWidth'(0) : PosWidth'(3);
    end else if (pos_i > PosWidth'(2)) begin
      pos_o = pos_inc;
      if (pos_inc[0]) begin
        shifter_o = shifted;
      end
      if (pos_inc > LastDataPos) begin
        res_o.frame = shifter_o;
        shifter_o   = '0;
        pos_o       = '0;
        res_o.done  = 1'b1;
        res_o.valid = ((res_o.frame[31:24] & res_o.frame[23:16]) == 8'd0) &&
                      ((res_o.frame[15:8] & res_o.frame[7:0]) == 8'd0);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nec_ir_frame_decoder_unit.sv =====
// Top level of the NEC infrared frame decoder: timing registers, decoder state
// and the result register. Depends on necir_pkg and necir_step.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   elapsed_ticks_i, pin_level_i
//   out      output     out_valid_o / out_stall_i frame_done_o, frame_valid_o, 4 bytes
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Every edge item gives one result item, registered and shown in the cycle after it is taken.
// A new item is taken every cycle unless the input stalls; the result register decouples the sides.
// The input stalls only while a result waits and the output stalls.
// Reset restores the default timing windows and clears position and frame.
`default_nettype none

module nec_ir_frame_decoder_unit #(
  parameter int unsigned ElapsedWidth = necir_pkg::ElapsedWidthDefault
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic [necir_pkg::ElapsedInWidth-1:0]   elapsed_ticks_i,
  input  wire logic                                   pin_level_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic                                        frame_done_o,
  output logic                                        frame_valid_o,
  output logic [7:0]                                  address_byte_o,
  output logic [7:0]                                  address_inverse_byte_o,
  output logic [7:0]                                  command_byte_o,
  output logic [7:0]                                  command_inverse_byte_o,
  input  wire logic                                   cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  wire logic [necir_pkg::CfgIndexWidth-1:0]    cfg_index_i,
  input  wire logic [necir_pkg::CfgDataWidth-1:0]     cfg_data_i
);
  import necir_pkg::*;

  timing_cfg_t         cfg_q;
  logic [PosWidth-1:0] pos_q, pos_d;
  logic [31:0]         shifter_q, shifter_d;
  logic [31:0]         held_q;
  step_res_t           res_d;
  step_res_t           res_q;
  logic                out_valid_q;
  logic                in_accept;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  necir_step #(
    .ElapsedWidth(ElapsedWidth)
  ) u_step (
    .cfg_i          (cfg_q),
    .elapsed_ticks_i(elapsed_ticks_i),
    .pin_level_i    (pin_level_i),
    .pos_i          (pos_q),
    .shifter_i      (shifter_q),
    .held_i         (held_q),
    .pos_o          (pos_d),
    .shifter_o      (shifter_d),
    .res_o          (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_max <= LeaderMaxReset;
      cfg_q.leader_min <= LeaderMinReset;
      cfg_q.space_max  <= SpaceMaxReset;
      cfg_q.space_min  <= SpaceMinReset;
      cfg_q.bit_max    <= BitMaxReset;
      cfg_q.bit_min    <= BitMinReset;
      cfg_q.one_thresh <= OneThreshReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgLeaderMax: cfg_q.leader_max <= cfg_data_i;
        CfgLeaderMin: cfg_q.leader_min <= cfg_data_i;
        CfgSpaceMax:  cfg_q.space_max  <= cfg_data_i;
        CfgSpaceMin:  cfg_q.space_min  <= cfg_data_i;
        CfgBitMax:    cfg_q.bit_max    <= cfg_data_i;
        CfgBitMin:    cfg_q.bit_min    <= cfg_data_i;
        CfgOneThresh: cfg_q.one_thresh <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      shifter_q <= '0;
      held_q    <= '0;
    end else if (in_accept) begin
      pos_q     <= pos_d;
      shifter_q <= shifter_d;
      held_q    <= res_d.frame;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign frame_done_o           = res_q.done;
  assign frame_valid_o          = res_q.valid;
  assign address_byte_o         = res_q.frame[31:24];
  assign address_inverse_byte_o = res_q.frame[23:16];
  assign command_byte_o         = res_q.frame[15:8];
  assign command_inverse_byte_o = res_q.frame[7:0];

endmodule

`default_nettype wire

// ===== verif/nec_ir_frame_decoder_unit_test.sv =====
// Self-checking testbench for nec_ir_frame_decoder_unit: drives sensor edges and timing
// register writes, predicts every result item and compares it with the block's output.
// Depends on necir_pkg and the nec_ir_frame_decoder_unit RTL only.
module nec_ir_frame_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import necir_pkg::*;

  localparam logic [CfgIndexWidth-1:0] CfgUnused = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [ElapsedInWidth-1:0] elapsed_ticks_i = '0;
  logic pin_level_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic frame_done_o;
  logic frame_valid_o;
  logic [7:0] address_byte_o;
  logic [7:0] address_inverse_byte_o;
  logic [7:0] command_byte_o;
  logic [7:0] command_inverse_byte_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIndexWidth-1:0] cfg_index_i = '0;
  logic [CfgDataWidth-1:0] cfg_data_i = '0;

  timing_cfg_t timing = {LeaderMaxReset, LeaderMinReset, SpaceMaxReset, SpaceMinReset,
                         BitMaxReset, BitMinReset, OneThreshReset};
  logic [PosWidth-1:0] position = '0;
  logic [31:0] shifter = '0;
  logic [31:0] held = '0;

  step_res_t edge_reports_due[$];
  int unsigned edges_sent = 0;
  int unsigned mismatch_count = 0;
  bit calm = 1'b0;

  nec_ir_frame_decoder_unit DUT (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .elapsed_ticks_i        (elapsed_ticks_i),
    .pin_level_i            (pin_level_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .frame_done_o           (frame_done_o),
    .frame_valid_o          (frame_valid_o),
    .address_byte_o         (address_byte_o),
    .address_inverse_byte_o (address_inverse_byte_o),
    .command_byte_o         (command_byte_o),
    .command_inverse_byte_o (command_inverse_byte_o),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 7);
  end

  function automatic step_res_t decode_edge(logic [ElapsedInWidth-1:0] ticks, logic pin);
    logic [CfgDataWidth-1:0] lo;
    logic [CfgDataWidth-1:0] hi;
    step_res_t res;
    res = '0;
    if (position <= 7'd1) begin
      lo = timing.leader_min;
      hi = timing.leader_max;
    end else if (position == 7'd2) begin
      lo = timing.space_min;
      hi = timing.space_max;
    end else begin
      lo = timing.bit_min;
      hi = timing.bit_max;
    end
    if (ticks > lo && ticks < hi) begin
      if (position == 7'd1) begin
        position = pin ? 7'd2 : 7'd0;
      end else if (position == 7'd2) begin
        position = pin ? 7'd0 : 7'd3;
      end else if (position > 7'd2) begin
        position = position + 7'd1;
        if (position[0]) begin
          shifter = {shifter[30:0], ticks > timing.one_thresh};
        end
        if (position > LastDataPos) begin
          held = shifter;
          shifter = '0;
          position = '0;
          res.done = 1'b1;
          res.valid = ((held[31:24] & held[23:16]) == 8'h00) &&
                      ((held[15:8] & held[7:0]) == 8'h00);
        end
      end
    end else begin
      position = pin ? 7'd0 : 7'd1;
      held = FrameAllOnes;
    end
    res.frame = held;
    return res;
  endfunction

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : scoreboard
    step_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (edge_reports_due.size() == 0) begin
        $display("%0t: result item with none expected, actual %b %b %h %h %h %h", $time,
                 frame_done_o, frame_valid_o, address_byte_o, address_inverse_byte_o,
                 command_byte_o, command_inverse_byte_o);
        mismatch_count++;
      end else begin
        want = edge_reports_due.pop_front();
        check_field("frame_done", 8'(want.done), 8'(frame_done_o));
        check_field("frame_valid", 8'(want.valid), 8'(frame_valid_o));
        check_field("address_byte", want.frame[31:24], address_byte_o);
        check_field("address_inverse_byte", want.frame[23:16], address_inverse_byte_o);
        check_field("command_byte", want.frame[15:8], command_byte_o);
        check_field("command_inverse_byte", want.frame[7:0], command_inverse_byte_o);
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      edge_reports_due.push_back(decode_edge(elapsed_ticks_i, pin_level_i));
    end
  end

  function automatic logic [ElapsedInWidth-1:0] pick_inside(int unsigned lo, int unsigned hi);
    if (hi > lo + 1) begin
      return ElapsedInWidth'($urandom_range(hi - 1, lo + 1));
    end
    return ElapsedInWidth'(hi);
  endfunction

  function automatic logic [ElapsedInWidth-1:0] random_ticks();
    case ($urandom_range(3))
      0: return ElapsedInWidth'($urandom);
      1: return ElapsedInWidth'($urandom_range(65535, 0));
      2: return pick_inside(timing.bit_min, timing.bit_max);
      default: return ElapsedInWidth'($urandom_range(timing.leader_max + 1,
                                                     timing.leader_min));
    endcase
  endfunction

  task automatic send_edge(input logic [ElapsedInWidth-1:0] ticks, input logic pin);
    int unsigned gap;
    if (!calm && $urandom_range(99) < 7) begin
      gap = $urandom_range(8, 1);
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    elapsed_ticks_i <= ticks;
    pin_level_i <= pin;
    do @(posedge clk_i); while (in_stall_o);
    edges_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (edge_reports_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgLeaderMax: timing.leader_max = data;
      CfgLeaderMin: timing.leader_min = data;
      CfgSpaceMax:  timing.space_max = data;
      CfgSpaceMin:  timing.space_min = data;
      CfgBitMax:    timing.bit_max = data;
      CfgBitMin:    timing.bit_min = data;
      CfgOneThresh: timing.one_thresh = data;
      default: ;
    endcase
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  task automatic program_windows(input logic [15:0] lmax, input logic [15:0] lmin,
                                 input logic [15:0] smax, input logic [15:0] smin,
                                 input logic [15:0] bmax, input logic [15:0] bmin,
                                 input logic [15:0] thr);
    wait_drained();
    write_reg(CfgLeaderMax, lmax);
    write_reg(CfgLeaderMin, lmin);
    write_reg(CfgSpaceMax, smax);
    write_reg(CfgSpaceMin, smin);
    write_reg(CfgBitMax, bmax);
    write_reg(CfgBitMin, bmin);
    write_reg(CfgOneThresh, thr);
  endtask

  // One edge item is replaced by a random one when break_at names its index.
  task automatic send_frame(input logic [31:0] word, input int break_at);
    int unsigned beyond;
    int unsigned one_lo;
    int unsigned zero_hi;
    logic [ElapsedInWidth-1:0] ticks;
    logic pin;
    beyond = timing.leader_max;
    if (timing.space_max > beyond) beyond = timing.space_max;
    if (timing.bit_max > beyond) beyond = timing.bit_max;
    one_lo = (timing.one_thresh > timing.bit_min) ? timing.one_thresh : timing.bit_min;
    zero_hi = timing.one_thresh + 1;
    if (timing.bit_max < zero_hi) zero_hi = timing.bit_max;
    for (int k = 0; k < 67; k++) begin
      if (k == 0) begin
        ticks = ElapsedInWidth'($urandom_range(24'hFFFFFF, beyond));
        pin = 1'b0;
      end else if (k == 1) begin
        ticks = pick_inside(timing.leader_min, timing.leader_max);
        pin = 1'b1;
      end else if (k == 2) begin
        ticks = pick_inside(timing.space_min, timing.space_max);
        pin = 1'b0;
      end else if (k[0]) begin
        ticks = pick_inside(timing.bit_min, timing.bit_max);
        pin = 1'b1;
      end else begin
        ticks = word[31 - (k - 4) / 2] ? pick_inside(one_lo, timing.bit_max)
                                        : pick_inside(timing.bit_min, zero_hi);
        pin = 1'b0;
      end
      if (k == break_at) begin
        ticks = random_ticks();
        pin = 1'($urandom_range(1));
      end
      send_edge(ticks, pin);
    end
  endtask

  task automatic test_window_edges();
    send_edge(24'd12000, 1'b1);
    send_edge(24'd0, 1'b1);
    send_edge(24'hFFFFFF, 1'b0);
    send_edge(24'd10000, 1'b1);
    send_edge(24'hFFFFFF, 1'b0);
    send_edge(24'd13750, 1'b0);
    send_edge(24'd13749, 1'b0);
    send_edge(24'hFFFFFF, 1'b0);
    send_edge(24'd10001, 1'b1);
    send_edge(24'd5000, 1'b1);
    send_edge(24'hFFFFFF, 1'b0);
    send_edge(24'd12000, 1'b1);
    send_edge(24'd3750, 1'b0);
    send_edge(24'd12000, 1'b1);
    send_edge(24'd6874, 1'b0);
    send_edge(24'd250, 1'b1);
    send_edge(24'hFFFFFF, 1'b0);
    send_edge(24'd12000, 1'b1);
    send_edge(24'd3751, 1'b0);
    send_edge(24'd251, 1'b1);
    send_edge(24'd1251, 1'b0);
    send_edge(24'd2874, 1'b1);
    send_edge(24'd2875, 1'b0);
    send_edge(24'h010000, 1'b1);
  endtask

  task automatic test_frames(input int unsigned count, input int unsigned broken_pct);
    logic [7:0] a;
    logic [7:0] c;
    logic [31:0] word;
    for (int unsigned i = 0; i < count; i++) begin
      a = 8'($urandom);
      c = 8'($urandom);
      case ($urandom_range(3))
        0: word = {a, ~a, c, ~c};
        1: word = $urandom;
        2: word = {a, ~a & 8'($urandom), c, ~c & 8'($urandom)};
        default: word = {a, ~a ^ (8'h01 << $urandom_range(7)), c, ~c};
      endcase
      send_frame(word, ($urandom_range(99) < broken_pct) ? int'($urandom_range(66)) : -1);
    end
  endtask

  task automatic test_noise(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_edge(random_ticks(), 1'($urandom_range(1)));
    end
  endtask

  task automatic test_custom_windows();
    int unsigned lmin;
    int unsigned smin;
    int unsigned bmin;
    int unsigned thr;
    for (int round = 0; round < 2; round++) begin
      lmin = $urandom_range(20000, 2000);
      smin = $urandom_range(8000, 500);
      bmin = $urandom_range(400, 1);
      thr = bmin + $urandom_range(1500, 5);
      program_windows(16'(lmin + $urandom_range(8000, 10)), 16'(lmin),
                      16'(smin + $urandom_range(4000, 10)), 16'(smin),
                      16'(thr + $urandom_range(2000, 5)), 16'(bmin), 16'(thr));
      write_reg(CfgUnused, 16'($urandom));
      test_frames(3, 20);
      test_noise(80);
    end
  endtask

  task automatic test_extreme_windows();
    program_windows(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    test_noise(40);
    program_windows(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    test_noise(40);
    program_windows(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
    send_frame(32'hFFFF_FFFF, -1);
    send_frame(32'hFFFF_FFFF, -1);
    test_noise(20);
    program_windows(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_frame(32'h0000_0000, -1);
    send_frame(32'h0000_0000, -1);
    test_noise(20);
  endtask

  task automatic test_mixed_traffic(input int unsigned target);
    program_windows(LeaderMaxReset, LeaderMinReset, SpaceMaxReset, SpaceMinReset,
                    BitMaxReset, BitMinReset, OneThreshReset);
    while (edges_sent < target) begin
      if ($urandom_range(9) < 7) begin
        test_frames(1, 15);
      end else begin
        test_noise($urandom_range(20, 1));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    test_window_edges();
    test_frames(8, 0);
    calm = 1'b1;
    test_frames(4, 10);
    test_noise(40);
    calm = 1'b0;
    test_custom_windows();
    test_extreme_windows();
    test_mixed_traffic(1900);
    wait_drained();
    repeat (5) @(posedge clk_i);
    if (mismatch_count == 0 && edge_reports_due.size() == 0) begin
      $display("nec_ir_frame_decoder_unit: match");
    end else begin
      $display("nec_ir_frame_decoder_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("nec_ir_frame_decoder_unit: mismatch");
    $finish;
  end

endmodule
